FILE: hdl/hsvrgb_pkg.sv
// hsvrgb_pkg: shared constants and types for the hsv to rgb converter
// no dependencies; imported by hsvrgb_scale, hsv_to_rgb_converter_top and the bench
package hsvrgb_pkg;

    // input field widths
    localparam int HUE_W = 15;
    localparam int PCT_W = 7;
    localparam int CH_W  = 8;

    // hue geometry in 1/64 degree units
    localparam int SECTOR_Q6  = 3840;
    localparam int HUE_MAX_Q6 = 23040;
    localparam int PCT_MAX    = 100;

    // internal widths
    localparam int BAND_W  = 13;  // offset into a 120 degree band, 0..7680
    localparam int FRAC_W  = 12;  // secondary weight, 0..3840
    localparam int INNER_W = 19;  // s*q + (100-s)*3840, up to 384000
    localparam int NUM_W   = 26;  // v * inner, up to 38400000
    localparam int PROD_W  = 34;  // 255*num and (qe+1)*den

    // exact scaling: channel = floor(255 * num / SCALE_DEN)
    localparam longint SCALE_DEN   = 64'd38400000;
    localparam int     RECIP_W     = 17;
    localparam int     SCALE_SHIFT = 34;
    // floor(255 * 2^34 / SCALE_DEN), estimate is exact or one low
    localparam int     SCALE_RECIP = 114085;
    localparam int     MULT_W      = NUM_W + RECIP_W;

    // pipeline depth: three front stages plus the scaler
    localparam int FRONT_LAT = 3;
    localparam int SCALE_LAT = 4;
    localparam int PIPE_LAT  = FRONT_LAT + SCALE_LAT;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef enum logic [1:0] {
        PICK_ZERO   = 2'd0,
        PICK_CHROMA = 2'd1,
        PICK_SECOND = 2'd2
    } t_pick;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    // operands handed to one channel scaler
    typedef struct packed {
        logic [INNER_W-1:0] inner;
        logic [PCT_W-1:0]   value;
    } t_scale_in;

    // routing of chroma and the secondary term per sector and channel
    function automatic t_pick pick_term(input t_sector sec, input t_chan ch);
        t_pick p;
        p = PICK_ZERO;
        case (sec)
            SEC_0: begin
                p = (ch == CH_RED) ? PICK_CHROMA : (ch == CH_GREEN) ? PICK_SECOND : PICK_ZERO;
            end
            SEC_1: begin
                p = (ch == CH_RED) ? PICK_SECOND : (ch == CH_GREEN) ? PICK_CHROMA : PICK_ZERO;
            end
            SEC_2: begin
                p = (ch == CH_RED) ? PICK_ZERO : (ch == CH_GREEN) ? PICK_CHROMA : PICK_SECOND;
            end
            SEC_3: begin
                p = (ch == CH_RED) ? PICK_ZERO : (ch == CH_GREEN) ? PICK_SECOND : PICK_CHROMA;
            end
            SEC_4: begin
                p = (ch == CH_RED) ? PICK_SECOND : (ch == CH_GREEN) ? PICK_ZERO : PICK_CHROMA;
            end
            default: begin
                p = (ch == CH_RED) ? PICK_CHROMA : (ch == CH_GREEN) ? PICK_ZERO : PICK_SECOND;
            end
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/hsvrgb_scale.sv
// hsvrgb_scale: four-stage exact floor(255 * value * inner / 38400000)
// depends on hsvrgb_pkg
module hsvrgb_scale
    import hsvrgb_pkg::*;
(
    input  logic             i_clk,
    input  t_scale_in        i_op,
    output logic [CH_W-1:0]  o_chan
);

    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(SCALE_RECIP);
    localparam logic [NUM_W-1:0]   DEN   = NUM_W'(SCALE_DEN);

    logic [NUM_W-1:0]  r_num_a, n_num_a;
    logic [NUM_W-1:0]  r_num_b;
    logic [CH_W-1:0]   r_qe_b, n_qe_b;
    logic [PROD_W-1:0] r_p_c, n_p_c;
    logic [PROD_W-1:0] r_t_c, n_t_c;
    logic [CH_W-1:0]   r_qe_c;
    logic [CH_W-1:0]   r_q_d, n_q_d;
    logic [MULT_W-1:0] w_est;

    // stage a: full numerator
    assign n_num_a = NUM_W'(NUM_W'(i_op.value) * NUM_W'(i_op.inner));

    // stage b: reciprocal estimate, exact or one low
    assign w_est  = MULT_W'(r_num_a) * MULT_W'(RECIP);
    assign n_qe_b = w_est[SCALE_SHIFT +: CH_W];

    // stage c: scaled numerator and next quotient boundary
    assign n_p_c = (PROD_W'(r_num_b) << 8) - PROD_W'(r_num_b);
    assign n_t_c = PROD_W'((PROD_W'(r_qe_b) + PROD_W'(1)) * PROD_W'(DEN));

    // stage d: one step correction
    assign n_q_d = r_qe_c + ((r_p_c >= r_t_c) ? CH_W'(1) : CH_W'(0));

    always_ff @(posedge i_clk) begin
        r_num_a <= n_num_a;
        r_num_b <= r_num_a;
        r_qe_b  <= n_qe_b;
        r_p_c   <= n_p_c;
        r_t_c   <= n_t_c;
        r_qe_c  <= r_qe_b;
        r_q_d   <= n_q_d;
    end

    assign o_chan = r_q_d;

endmodule

FILE: hdl/hsv_to_rgb_converter_top.sv
// hsv_to_rgb_converter_top: pipelined hsv pixel to 8-bit rgb conversion
// depends on hsvrgb_pkg and hsvrgb_scale
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+----------------------
//  pixel in | i_hue_q6, i_saturation_pct, i_value_pct        | start && !busy
//  rgb out  | o_red, o_green, o_blue, o_in_range             | o_done, one cycle
//
// one pixel transfer per clock; busy never rises, so a pixel may arrive every cycle
// a result appears on o_done after its transfer has passed three front stages
// (sector, band weight, channel routing) and four in each channel scaler
// (multiply, reciprocal estimate, boundary products, correction)
// synchronous active-low reset clears the valid pipe; data registers carry no reset
// the receiver cannot stall, so nothing in the pipe ever holds
module hsv_to_rgb_converter_top
    import hsvrgb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [HUE_W-1:0] i_hue_q6,
    input  logic [PCT_W-1:0] i_saturation_pct,
    input  logic [PCT_W-1:0] i_value_pct,
    output logic             o_done,
    output logic [CH_W-1:0]  o_red,
    output logic [CH_W-1:0]  o_green,
    output logic [CH_W-1:0]  o_blue,
    output logic             o_in_range
);

    localparam logic [HUE_W-1:0]  SEC1 = HUE_W'(SECTOR_Q6);
    localparam logic [HUE_W-1:0]  SEC2 = HUE_W'(2 * SECTOR_Q6);
    localparam logic [HUE_W-1:0]  SEC3 = HUE_W'(3 * SECTOR_Q6);
    localparam logic [HUE_W-1:0]  SEC4 = HUE_W'(4 * SECTOR_Q6);
    localparam logic [HUE_W-1:0]  SEC5 = HUE_W'(5 * SECTOR_Q6);
    localparam logic [HUE_W-1:0]  HMAX = HUE_W'(HUE_MAX_Q6);
    localparam logic [PCT_W-1:0]  PMAX = PCT_W'(PCT_MAX);
    localparam logic [BAND_W-1:0] HALF = BAND_W'(SECTOR_Q6);
    localparam logic [FRAC_W-1:0] FULL = FRAC_W'(SECTOR_Q6);

    logic w_accept;
    logic w_rng;

    // valid and range flags travel alongside the data
    logic [PIPE_LAT-1:0] r_vld, n_vld;
    logic [PIPE_LAT-1:0] r_rng, n_rng;

    // stage 1
    t_sector           r_sec1, n_sec1;
    logic [BAND_W-1:0] r_band1, n_band1;
    logic [PCT_W-1:0]  r_sat1, r_val1;

    // stage 2
    t_sector            r_sec2;
    logic [FRAC_W-1:0]  r_frac2, n_frac2;
    logic [INNER_W-1:0] r_base2, n_base2;
    logic [PCT_W-1:0]   r_sat2, r_val2;
    logic [BAND_W-1:0]  w_dist;

    // stage 3
    t_scale_in r_op_r, r_op_g, r_op_b;
    t_scale_in n_op_r, n_op_g, n_op_b;

    logic [CH_W-1:0] w_red, w_green, w_blue;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_rng    = (i_hue_q6 <= HMAX) && (i_saturation_pct <= PMAX)
                   && (i_value_pct <= PMAX);

    // valid and range shift
    assign n_vld = {r_vld[PIPE_LAT-2:0], w_accept};
    assign n_rng = {r_rng[PIPE_LAT-2:0], w_rng};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rng <= n_rng;
    end

    // stage 1: sector and offset into the 120 degree band
    always_comb begin
        if (i_hue_q6 >= SEC5) begin
            n_sec1 = SEC_5;
        end else if (i_hue_q6 >= SEC4) begin
            n_sec1 = SEC_4;
        end else if (i_hue_q6 >= SEC3) begin
            n_sec1 = SEC_3;
        end else if (i_hue_q6 >= SEC2) begin
            n_sec1 = SEC_2;
        end else if (i_hue_q6 >= SEC1) begin
            n_sec1 = SEC_1;
        end else begin
            n_sec1 = SEC_0;
        end
        // hue at 360 lands on the top of the band, which gives the same weight as zero
        if (i_hue_q6 >= SEC4) begin
            n_band1 = BAND_W'(i_hue_q6 - SEC4);
        end else if (i_hue_q6 >= SEC2) begin
            n_band1 = BAND_W'(i_hue_q6 - SEC2);
        end else begin
            n_band1 = BAND_W'(i_hue_q6);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec1  <= n_sec1;
        r_band1 <= n_band1;
        r_sat1  <= i_saturation_pct;
        r_val1  <= i_value_pct;
    end

    // stage 2: secondary weight and the shared (100 - s) * 3840 term
    assign w_dist  = (r_band1 >= HALF) ? (r_band1 - HALF) : (HALF - r_band1);
    assign n_frac2 = FULL - FRAC_W'(w_dist);
    assign n_base2 = INNER_W'(INNER_W'(PMAX - r_sat1) * INNER_W'(SECTOR_Q6));

    always_ff @(posedge i_clk) begin
        r_sec2  <= r_sec1;
        r_frac2 <= n_frac2;
        r_base2 <= n_base2;
        r_sat2  <= r_sat1;
        r_val2  <= r_val1;
    end

    // stage 3: route chroma or secondary term to each channel
    function automatic logic [INNER_W-1:0] chan_inner(
        input t_pick             p,
        input logic [PCT_W-1:0]  sat,
        input logic [FRAC_W-1:0] frac,
        input logic [INNER_W-1:0] base
    );
        logic [FRAC_W-1:0] q;
        case (p)
            PICK_CHROMA: q = FULL;
            PICK_SECOND: q = frac;
            default:     q = '0;
        endcase
        return INNER_W'(INNER_W'(sat) * INNER_W'(q)) + base;
    endfunction

    always_comb begin
        n_op_r.inner = chan_inner(pick_term(r_sec2, CH_RED), r_sat2, r_frac2, r_base2);
        n_op_r.value = r_val2;
        n_op_g.inner = chan_inner(pick_term(r_sec2, CH_GREEN), r_sat2, r_frac2, r_base2);
        n_op_g.value = r_val2;
        n_op_b.inner = chan_inner(pick_term(r_sec2, CH_BLUE), r_sat2, r_frac2, r_base2);
        n_op_b.value = r_val2;
    end

    always_ff @(posedge i_clk) begin
        r_op_r <= n_op_r;
        r_op_g <= n_op_g;
        r_op_b <= n_op_b;
    end

    // per channel exact scaling
    hsvrgb_scale u_scale_r (.i_clk(i_clk), .i_op(r_op_r), .o_chan(w_red));
    hsvrgb_scale u_scale_g (.i_clk(i_clk), .i_op(r_op_g), .o_chan(w_green));
    hsvrgb_scale u_scale_b (.i_clk(i_clk), .i_op(r_op_b), .o_chan(w_blue));

    // result, forced to zero for an out-of-range pixel
    assign o_done     = r_vld[PIPE_LAT-1];
    assign o_in_range = r_rng[PIPE_LAT-1];
    assign o_red      = o_in_range ? w_red   : '0;
    assign o_green    = o_in_range ? w_green : '0;
    assign o_blue     = o_in_range ? w_blue  : '0;

    // every transfer gives exactly one result after the pipe depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_done)
        else $error("result missing after transfer");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##PIPE_LAT !o_done)
        else $error("result without transfer");

    // range flag lines up with the pixel that produced it
    a_range_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT (o_in_range == $past(w_rng, PIPE_LAT)))
        else $error("range flag misaligned");

    // full value at zero saturation is pure white
    a_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_saturation_pct == '0 && i_value_pct == PMAX
            && i_hue_q6 <= HMAX)
        |-> ##PIPE_LAT (o_red == '1 && o_green == '1 && o_blue == '1))
        else $error("white pixel wrong");

endmodule

FILE: bench/hsv_to_rgb_converter_top_tb.sv
// hsv_to_rgb_converter_top_tb: self-checking bench for the hsv to rgb pixel converter
// drives a directed table and then random pixels, checking each rgb result against typed expectations or a local model
// depends on hsvrgb_pkg and hsv_to_rgb_converter_top
module hsv_to_rgb_converter_top_tb
    import hsvrgb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL_SCALE   = 255;
    localparam int RANDOM_ITEMS = 1100;

    // one rgb result as the block reports it
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            in_range;
    } t_pixel_rgb;

    // one row of the directed table; typed rows carry their own expected rgb
    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
        bit               typed;
        t_pixel_rgb       rgb;
    } t_hsv_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [HUE_W-1:0] i_hue_q6;
    logic [PCT_W-1:0] i_saturation_pct;
    logic [PCT_W-1:0] i_value_pct;
    logic             o_done;
    logic [CH_W-1:0]  o_red;
    logic [CH_W-1:0]  o_green;
    logic [CH_W-1:0]  o_blue;
    logic             o_in_range;

    t_pixel_rgb expected_rgb[$];
    t_hsv_row   directed_rows[$];
    int         pixels_sent;
    int         out_of_range_sent;
    int         results_checked;
    int         mismatches;

    hsv_to_rgb_converter_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_hue_q6         (i_hue_q6),
        .i_saturation_pct (i_saturation_pct),
        .i_value_pct      (i_value_pct),
        .o_done           (o_done),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_in_range       (o_in_range)
    );

    // clock, 4 ns period
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // exact integer hsv to rgb over the common denominator 10000 * 3840
    function automatic t_pixel_rgb hsv_pixel_to_rgb(input logic [HUE_W-1:0] hue,
                                                    input logic [PCT_W-1:0] sat,
                                                    input logic [PCT_W-1:0] val);
        t_pixel_rgb      px;
        t_sector         sec;
        longint unsigned band;
        longint unsigned band_dist;
        longint unsigned wgt;
        longint unsigned chroma;
        longint unsigned second;
        longint unsigned offset;
        longint unsigned rn;
        longint unsigned gn;
        longint unsigned bn;
        px = '0;
        if (hue > HUE_MAX_Q6 || sat > PCT_MAX || val > PCT_MAX) begin
            return px;
        end
        // hue of 360 degrees stays in the last sector
        sec = (hue >= 5 * SECTOR_Q6) ? SEC_5 : t_sector'(hue / SECTOR_Q6);
        // distance into the 120 degree band gives the secondary weight
        band      = longint'(hue) % (2 * SECTOR_Q6);
        band_dist = (band >= SECTOR_Q6) ? band - SECTOR_Q6 : SECTOR_Q6 - band;
        wgt       = SECTOR_Q6 - band_dist;
        chroma    = longint'(sat) * longint'(val) * SECTOR_Q6;
        second    = longint'(sat) * longint'(val) * wgt;
        offset    = longint'(PCT_MAX - sat) * longint'(val) * SECTOR_Q6;
        case (sec)
            SEC_0: begin rn = chroma; gn = second; bn = 0;      end
            SEC_1: begin rn = second; gn = chroma; bn = 0;      end
            SEC_2: begin rn = 0;      gn = chroma; bn = second; end
            SEC_3: begin rn = 0;      gn = second; bn = chroma; end
            SEC_4: begin rn = second; gn = 0;      bn = chroma; end
            default: begin rn = chroma; gn = 0;    bn = second; end
        endcase
        px.red      = CH_W'(((rn + offset) * FULL_SCALE) / SCALE_DEN);
        px.green    = CH_W'(((gn + offset) * FULL_SCALE) / SCALE_DEN);
        px.blue     = CH_W'(((bn + offset) * FULL_SCALE) / SCALE_DEN);
        px.in_range = 1'b1;
        return px;
    endfunction

    task automatic add_row(input int hue, input int sat, input int val, input bit typed,
                           input int red, input int green, input int blue, input bit ok);
        t_hsv_row row;
        row.hue          = HUE_W'(hue);
        row.sat          = PCT_W'(sat);
        row.val          = PCT_W'(val);
        row.typed        = typed;
        row.rgb.red      = CH_W'(red);
        row.rgb.green    = CH_W'(green);
        row.rgb.blue     = CH_W'(blue);
        row.rgb.in_range = ok;
        directed_rows.push_back(row);
    endtask

    // drive one pixel from a falling edge, hold until transferred, then idle for the requested gap
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                              input logic [PCT_W-1:0] val, input t_pixel_rgb want,
                              input int unsigned gap);
        i_hue_q6         = hue;
        i_saturation_pct = sat;
        i_value_pct      = val;
        start            = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_rgb.push_back(want);
        pixels_sent++;
        if (!want.in_range) begin
            out_of_range_sent++;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result check on every strobe against the oldest pending expectation
    always @(posedge i_clk) begin
        t_pixel_rgb want;
        if (i_rst_n && o_done) begin
            if (expected_rgb.size() == 0) begin
                $display("%0t ns: unexpected result, actual rgb %0d %0d %0d in_range %0b",
                         $time, o_red, o_green, o_blue, o_in_range);
                mismatches++;
            end else begin
                want = expected_rgb.pop_front();
                results_checked++;
                report_field("red", want.red, o_red);
                report_field("green", want.green, o_green);
                report_field("blue", want.blue, o_blue);
                report_field("in_range", want.in_range, o_in_range);
            end
        end
    end

    // stimulus
    initial begin
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
        t_pixel_rgb       want;
        int               pick;
        int               near;
        bit               burst;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_hue_q6          = '0;
        i_saturation_pct  = '0;
        i_value_pct       = '0;
        pixels_sent       = 0;
        out_of_range_sent = 0;
        results_checked   = 0;
        mismatches        = 0;
        burst             = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // primaries, secondaries, white, black and hue of 360 degrees
        add_row(0,     100, 100, 1, 255, 0,   0,   1);
        add_row(3840,  100, 100, 1, 255, 255, 0,   1);
        add_row(7680,  100, 100, 1, 0,   255, 0,   1);
        add_row(11520, 100, 100, 1, 0,   255, 255, 1);
        add_row(15360, 100, 100, 1, 0,   0,   255, 1);
        add_row(19200, 100, 100, 1, 255, 0,   255, 1);
        add_row(23040, 100, 100, 1, 255, 0,   0,   1);
        add_row(0,     0,   100, 1, 255, 255, 255, 1);
        add_row(12345, 100, 0,   1, 0,   0,   0,   1);
        add_row(0,     0,   0,   1, 0,   0,   0,   1);
        // out-of-range inputs give zero rgb and a cleared flag
        add_row(23041, 50,  50,  1, 0,   0,   0,   0);
        add_row(32767, 127, 127, 1, 0,   0,   0,   0);
        add_row(1000,  101, 50,  1, 0,   0,   0,   0);
        add_row(1000,  50,  101, 1, 0,   0,   0,   0);
        add_row(23040, 100, 101, 1, 0,   0,   0,   0);
        // sector edges and odd mixes go through the model
        add_row(3839,  100, 100, 0, 0, 0, 0, 0);
        add_row(3841,  77,  63,  0, 0, 0, 0, 0);
        add_row(22000, 33,  99,  0, 0, 0, 0, 0);
        add_row(23039, 1,   1,   0, 0, 0, 0, 0);
        add_row(5000,  100, 1,   0, 0, 0, 0, 0);
        add_row(17000, 1,   100, 0, 0, 0, 0, 0);
        add_row(0,     100, 50,  0, 0, 0, 0, 0);
        add_row(16384, 64,  64,  0, 0, 0, 0, 0);
        add_row(19199, 99,  100, 0, 0, 0, 0, 0);

        foreach (directed_rows[i]) begin
            want = directed_rows[i].typed ? directed_rows[i].rgb
                 : hsv_pixel_to_rgb(directed_rows[i].hue, directed_rows[i].sat,
                                    directed_rows[i].val);
            send_pixel(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].val,
                       want, $urandom_range(0, 9));
        end

        // random pixels: mostly valid, some near sector edges, some full-range noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                hue = HUE_W'($urandom_range(0, 32767));
                sat = PCT_W'($urandom_range(0, 127));
                val = PCT_W'($urandom_range(0, 127));
            end else begin
                if (pick < 28) begin
                    near = $urandom_range(0, 6) * SECTOR_Q6 + $urandom_range(0, 6) - 3;
                    if (near < 0) near = 0;
                    if (near > HUE_MAX_Q6) near = HUE_MAX_Q6;
                    hue = HUE_W'(near);
                end else begin
                    hue = HUE_W'($urandom_range(0, HUE_MAX_Q6));
                end
                sat = ($urandom_range(0, 9) == 0) ? PCT_W'($urandom_range(0, 1) * PCT_MAX)
                                                  : PCT_W'($urandom_range(0, PCT_MAX));
                val = ($urandom_range(0, 9) == 0) ? PCT_W'($urandom_range(0, 1) * PCT_MAX)
                                                  : PCT_W'($urandom_range(0, PCT_MAX));
            end
            send_pixel(hue, sat, val, hsv_pixel_to_rgb(hue, sat, val),
                       burst ? 0 : $urandom_range(0, 9));
        end
        start = 1'b0;

        // drain, then keep watching past the pipe depth for stray strobes
        while (expected_rgb.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);

        $display("covered %0d pixels (%0d out of range) incl. all six sectors and 360 degrees",
                 pixels_sent, out_of_range_sent);
        $display("checked %0d rgb results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("hsv_to_rgb_converter_top_tb passed");
        end else begin
            $display("hsv_to_rgb_converter_top_tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_rgb.size());
        $display("hsv_to_rgb_converter_top_tb failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_scale.sv
hdl/hsv_to_rgb_converter_top.sv
bench/hsv_to_rgb_converter_top_tb.sv
